FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on rising edge, reset gated
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/lnws_pkg.sv
// ----------------------------------------------------------------------------
// lnws_pkg
// types, constants and tables of the lcd nibble write sequencer
// ----------------------------------------------------------------------------
package lnws_pkg;

    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned INIT_NIBBLES = 14;

    localparam logic [HOLD_W-1:0] RST_PULSE_HOLD   = 16'd500;
    localparam logic [HOLD_W-1:0] RST_POWERUP_WAIT = 16'd40000;
    localparam logic [HOLD_W-1:0] RST_WAKE_GAP     = 16'd200;
    localparam logic [HOLD_W-1:0] RST_CMD_GAP      = 16'd400;

    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_CHAR  = 2'd1,
        OP_UPPER = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_PULSE_HOLD   = 2'd0,
        CFG_POWERUP_WAIT = 2'd1,
        CFG_WAKE_GAP     = 2'd2,
        CFG_CMD_GAP      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_NIB,
        ST_POST
    } t_state;

    typedef enum logic [1:0] {
        PH_SET,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_WAKE,
        GAP_CMD
    } t_gap;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
        logic [3:0] nib_last;
    } t_job;

    typedef struct packed {
        logic [HOLD_W-1:0] pulse_hold;
        logic [HOLD_W-1:0] powerup_wait;
        logic [HOLD_W-1:0] wake_gap;
        logic [HOLD_W-1:0] cmd_gap;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic idle;
        logic init_run;
    } t_back_stat;

    // nibble sequence of the initialization: wake-ups, 4-bit mode, set-up bytes
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        unique case (idx)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd6:             nib = 4'h1;
            4'd7, 4'd8:       nib = 4'h0;
            4'd9:             nib = 4'hF;
            4'd10:            nib = 4'h0;
            4'd11:            nib = 4'h6;
            4'd12:            nib = 4'h0;
            4'd13:            nib = 4'h1;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic t_gap init_gap(input logic [3:0] idx);
        t_gap g;
        if (idx < 4'd3) begin
            g = GAP_WAKE;
        end else if (idx == 4'd3) begin
            g = GAP_CMD;
        end else if (idx[0]) begin
            g = GAP_CMD;
        end else begin
            g = GAP_NONE;
        end
        return g;
    endfunction

endpackage

FILE: rtl/lcd_req_if.sv
// ----------------------------------------------------------------------------
// lcd_req_if
// request channel: operation code and byte
// ----------------------------------------------------------------------------
interface lcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

FILE: rtl/lcd_pin_if.sv
// ----------------------------------------------------------------------------
// lcd_pin_if
// pin state channel: data lines, rs, enable, hold time, last marker
// ----------------------------------------------------------------------------
interface lcd_pin_if;
    logic        valid;
    logic        ready;
    logic [3:0]  data_nibble;
    logic        reg_select;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;

    modport source (output valid, output data_nibble, output reg_select,
                    output enable, output hold_us, output last, input ready);
    modport sink   (input valid, input data_nibble, input reg_select,
                    input enable, input hold_us, input last, output ready);
endinterface

FILE: rtl/lnws_front.sv
// ----------------------------------------------------------------------------
// lnws_front
// accepts requests and classifies them into sequencer jobs
// ----------------------------------------------------------------------------
module lnws_front
    import lnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcd_req_if.sink     i_req,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    logic r_valid;
    t_job r_job;
    t_job w_job;
    logic w_take;

    always_comb begin
        w_job.op    = t_op'(i_req.cmd);
        w_job.value = i_req.value;
        unique case (t_op'(i_req.cmd))
            OP_CMD:   w_job.nib_last = 4'd1;
            OP_CHAR:  w_job.nib_last = 4'd1;
            OP_UPPER: w_job.nib_last = 4'd0;
            OP_INIT:  w_job.nib_last = 4'(INIT_NIBBLES - 1);
            default:  w_job.nib_last = 4'd0;
        endcase
    end

    assign o_push      = r_valid && !i_q_stat.full;
    assign i_req.ready = !r_valid || !i_q_stat.full;
    assign w_take      = i_req.valid && i_req.ready;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= w_job;
        end
    end

endmodule

FILE: rtl/lnws_queue.sv
// ----------------------------------------------------------------------------
// lnws_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module lnws_queue
    import lnws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr  = i_push && !o_stat.full;
    assign w_rd  = i_pop && !o_stat.empty;
    assign o_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/lnws_back.sv
// ----------------------------------------------------------------------------
// lnws_back
// pin state sequencer: walks one job, when the output is not stalled one pin state per cycle
// ----------------------------------------------------------------------------
module lnws_back
    import lnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q_stat     i_q_stat,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output t_back_stat  o_stat,
    lcd_pin_if.source   o_pin
);

    t_state            r_state;
    t_state            n_state;
    t_job              r_job;
    logic [3:0]        r_nib;
    t_phase            r_phase;
    logic [3:0]        r_data_lines;

    logic              r_o_valid;
    logic [3:0]        r_o_data;
    logic              r_o_rs;
    logic              r_o_en;
    logic [HOLD_W-1:0] r_o_hold;
    logic              r_o_last;

    logic              w_out_free;
    logic              w_nib_done;
    logic [3:0]        w_nibble;
    logic [HOLD_W-1:0] w_gap;
    logic [HOLD_W:0]   w_sum;
    logic [HOLD_W-1:0] w_sat;
    t_gap              w_gap_sel;

    logic              w_emit;
    logic [3:0]        w_data;
    logic              w_rs;
    logic              w_en;
    logic [HOLD_W-1:0] w_hold;
    logic              w_last;

    assign w_out_free = !r_o_valid || o_pin.ready;
    assign w_nib_done = (r_nib == r_job.nib_last);
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_stat.empty;

    assign o_stat.idle     = (r_state == ST_IDLE);
    assign o_stat.init_run = (r_state != ST_IDLE) && (r_job.op == OP_INIT);

    // nibble and gap of the current step
    always_comb begin
        if (r_job.op == OP_INIT) begin
            w_nibble  = init_nibble(r_nib);
            w_gap_sel = init_gap(r_nib);
        end else begin
            w_nibble  = (r_nib == 4'd0) ? r_job.value[7:4] : r_job.value[3:0];
            w_gap_sel = GAP_NONE;
        end
        unique case (w_gap_sel)
            GAP_WAKE: w_gap = i_cfg.wake_gap;
            GAP_CMD:  w_gap = i_cfg.cmd_gap;
            default:  w_gap = '0;
        endcase
        w_sum = {1'b0, i_cfg.pulse_hold} + {1'b0, w_gap};
        w_sat = w_sum[HOLD_W] ? {HOLD_W{1'b1}} : w_sum[HOLD_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = (i_q_job.op == OP_CHAR || i_q_job.op == OP_INIT)
                              ? ST_PRE : ST_NIB;
                end
            end
            ST_PRE: begin
                if (w_out_free) begin
                    n_state = ST_NIB;
                end
            end
            ST_NIB: begin
                if (w_out_free && r_phase == PH_LOW && w_nib_done) begin
                    n_state = (r_job.op == OP_CHAR) ? ST_POST : ST_IDLE;
                end
            end
            ST_POST: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // pin state of the current step
    always_comb begin
        w_emit = 1'b0;
        w_data = r_data_lines;
        w_rs   = 1'b0;
        w_en   = 1'b0;
        w_hold = '0;
        w_last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_emit = 1'b0;
            end
            ST_PRE: begin
                w_emit = w_out_free;
                w_rs   = (r_job.op == OP_CHAR);
                w_hold = (r_job.op == OP_INIT) ? i_cfg.powerup_wait : i_cfg.pulse_hold;
            end
            ST_NIB: begin
                w_emit = w_out_free;
                w_data = w_nibble;
                w_rs   = (r_job.op == OP_CHAR);
                w_en   = (r_phase == PH_HIGH);
                w_hold = (r_phase == PH_LOW) ? w_sat : i_cfg.pulse_hold;
                w_last = (r_phase == PH_LOW) && w_nib_done && (r_job.op != OP_CHAR);
            end
            ST_POST: begin
                w_emit = w_out_free;
                w_last = 1'b1;
            end
            default: w_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_SET;
            r_nib        <= '0;
            r_data_lines <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_nib   <= '0;
                r_phase <= PH_SET;
            end else if (r_state == ST_NIB && w_emit) begin
                unique case (r_phase)
                    PH_SET:  r_phase <= PH_HIGH;
                    PH_HIGH: r_phase <= PH_LOW;
                    PH_LOW: begin
                        r_phase <= PH_SET;
                        r_nib   <= r_nib + 1'b1;
                    end
                    default: r_phase <= PH_SET;
                endcase
            end
            if (r_state == ST_NIB && w_emit && r_phase == PH_SET) begin
                r_data_lines <= w_nibble;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (o_pin.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (w_emit) begin
            r_o_data <= w_data;
            r_o_rs   <= w_rs;
            r_o_en   <= w_en;
            r_o_hold <= w_hold;
            r_o_last <= w_last;
        end
    end

    assign o_pin.valid       = r_o_valid;
    assign o_pin.data_nibble = r_o_data;
    assign o_pin.reg_select  = r_o_rs;
    assign o_pin.enable      = r_o_en;
    assign o_pin.hold_us     = r_o_hold;
    assign o_pin.last        = r_o_last;

endmodule

FILE: rtl/lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer
// 4-bit character lcd write sequencer, request in, timed pin states out
// ----------------------------------------------------------------------------
// Each request (command byte, character byte, upper-nibble command or
// initialize) becomes an ordered run of pin states with hold times; the last
// is marked. The back-end sequencer emits one pin state per cycle when the
// output register is free, after it has loaded the job from the two-entry
// queue. Requests are accepted into the front stage and queue while the back
// end is still busy. Hold-time registers are written through the plain write
// port and should only change while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_nibble_write_sequencer
    import lnws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [HOLD_W-1:0] i_cfg_data,
    lcd_req_if.sink           i_req,
    lcd_pin_if.source         o_pin
);

    t_cfg       r_cfg;
    t_q_stat    w_q_stat;
    t_back_stat w_back_stat;
    t_job       w_push_job;
    t_job       w_q_job;
    logic       w_push;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_hold   <= RST_PULSE_HOLD;
            r_cfg.powerup_wait <= RST_POWERUP_WAIT;
            r_cfg.wake_gap     <= RST_WAKE_GAP;
            r_cfg.cmd_gap      <= RST_CMD_GAP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PULSE_HOLD:   r_cfg.pulse_hold   <= i_cfg_data;
                CFG_POWERUP_WAIT: r_cfg.powerup_wait <= i_cfg_data;
                CFG_WAKE_GAP:     r_cfg.wake_gap     <= i_cfg_data;
                CFG_CMD_GAP:      r_cfg.cmd_gap      <= i_cfg_data;
                default:          r_cfg.pulse_hold   <= r_cfg.pulse_hold;
            endcase
        end
    end

    lnws_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    lnws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_q_job),
        .o_stat  (w_q_stat)
    );

    lnws_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .i_q_job  (w_q_job),
        .o_q_pop  (w_pop),
        .o_stat   (w_back_stat),
        .o_pin    (o_pin)
    );

    // enable-high states always hold for the plain pulse time
    `AST_IMPLY(a_en_hold, i_clk, i_rst_n, o_pin.valid && o_pin.enable, o_pin.hold_us == r_cfg.pulse_hold)
    // a popped job leaves the sequencer busy next cycle
    `AST_NEXT(a_pop_busy, i_clk, i_rst_n, w_pop, !w_back_stat.idle)
    // pops only happen from an idle sequencer with data queued
    `AST_IMPLY(a_pop_legal, i_clk, i_rst_n, w_pop, w_back_stat.idle && !w_q_stat.empty)
    // rs is never raised during initialization
    `AST_IMPLY(a_init_rs, i_clk, i_rst_n, w_back_stat.init_run && o_pin.valid && !o_pin.last, !o_pin.reg_select)

endmodule

FILE: test/lcd_nibble_write_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer_test
// Self-checking bench for the lcd nibble write sequencer. Requests go in on
// the request channel with random gaps. Pin states come out on the pin channel
// under random back-pressure. Each accepted request is run through an internal
// pin-sequence predictor, and every pin state transfer is compared field by
// field with the oldest prediction. Directed tests cover power-up
// initialization, every operation, byte extremes and hold-time saturation.
// Random phases then use new hold settings in each phase.
// ----------------------------------------------------------------------------
module lcd_nibble_write_sequencer_test;
    import lnws_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam logic [3:0] WAKE_NIBBLE = 4'h3;
    localparam logic [3:0] MODE_NIBBLE = 4'h2;
    localparam logic [7:0] SETUP_BYTES [5] = '{8'h28, 8'h10, 8'h0F, 8'h06, 8'h01};

    typedef struct packed {
        logic [3:0]  data_nibble;
        logic        reg_select;
        logic        enable;
        logic [15:0] hold_us;
        logic        last;
    } t_pin_state;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [HOLD_W-1:0] i_cfg_data;

    lcd_req_if req_ch ();
    lcd_pin_if pin_ch ();

    lcd_nibble_write_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_pin      (pin_ch)
    );

    t_cfg       holds;
    logic [3:0] lines_now;
    logic       rs_now;
    t_pin_state pin_queue [$];
    t_pin_state pin_want;
    int         errors;
    bit         steady;
    int         stall_left;
    int         quiet_cycles;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_cycles();
        if ($urandom_range(0, 9) < 7) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic void push_pin(logic [3:0] nib, logic en, logic [15:0] hold);
        t_pin_state p;
        p.data_nibble = nib;
        p.reg_select  = rs_now;
        p.enable      = en;
        p.hold_us     = hold;
        p.last        = 1'b0;
        pin_queue.push_back(p);
    endfunction

    // data set, enable high, enable low with the gap merged and saturated
    function automatic void push_nibble(logic [3:0] nib, logic [15:0] gap);
        logic [16:0] sum;
        sum = {1'b0, holds.pulse_hold} + {1'b0, gap};
        lines_now = nib;
        push_pin(nib, 1'b0, holds.pulse_hold);
        push_pin(nib, 1'b1, holds.pulse_hold);
        push_pin(nib, 1'b0, sum[16] ? 16'hFFFF : sum[15:0]);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic [15:0] gap);
        push_nibble(b[7:4], 16'd0);
        push_nibble(b[3:0], gap);
    endfunction

    function automatic void predict_pins(t_op op, logic [7:0] value);
        case (op)
            OP_CMD: begin
                push_byte(value, 16'd0);
            end
            OP_CHAR: begin
                rs_now = 1'b1;
                push_pin(lines_now, 1'b0, holds.pulse_hold);
                push_byte(value, 16'd0);
                rs_now = 1'b0;
                push_pin(lines_now, 1'b0, 16'd0);
            end
            OP_UPPER: begin
                push_nibble(value[7:4], 16'd0);
            end
            default: begin
                push_pin(lines_now, 1'b0, holds.powerup_wait);
                repeat (3) push_nibble(WAKE_NIBBLE, holds.wake_gap);
                push_nibble(MODE_NIBBLE, holds.cmd_gap);
                foreach (SETUP_BYTES[i]) push_byte(SETUP_BYTES[i], holds.cmd_gap);
            end
        endcase
        pin_queue[pin_queue.size() - 1].last = 1'b1;
    endfunction

    task automatic send_request(t_op op, logic [7:0] value);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_cycles();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_pins(op, value);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pin_queue.size() != 0);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PULSE_HOLD:   holds.pulse_hold   = data;
            CFG_POWERUP_WAIT: holds.powerup_wait = data;
            CFG_WAKE_GAP:     holds.wake_gap     = data;
            default:          holds.cmd_gap      = data;
        endcase
    endtask

    task automatic set_holds(logic [15:0] pulse, logic [15:0] powerup,
                             logic [15:0] wake, logic [15:0] cmd_gap);
        settle();
        write_cfg(CFG_PULSE_HOLD, pulse);
        write_cfg(CFG_POWERUP_WAIT, powerup);
        write_cfg(CFG_WAKE_GAP, wake);
        write_cfg(CFG_CMD_GAP, cmd_gap);
    endtask

    function automatic logic [15:0] random_hold();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 1000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // power-up wait keeps the reset data lines and rs
    task automatic test_power_up_init();
        send_request(OP_INIT, 8'h00);
    endtask

    task automatic test_byte_writes();
        send_request(OP_CMD, 8'h00);
        send_request(OP_CMD, 8'hFF);
        send_request(OP_CMD, 8'hA5);
        send_request(OP_UPPER, 8'hF0);
        send_request(OP_UPPER, 8'h0F);
        send_request(OP_CHAR, 8'h00);
        send_request(OP_CHAR, 8'hFF);
        send_request(OP_CHAR, 8'h5A);
        send_request(OP_UPPER, 8'h9C);
        send_request(OP_CHAR, 8'h41);
        // power-up state now carries the low nibble of the last character
        send_request(OP_INIT, 8'hFF);
    endtask

    task automatic test_hold_extremes();
        set_holds(16'd0, 16'd0, 16'd0, 16'd0);
        send_request(OP_CMD, 8'h3C);
        send_request(OP_CHAR, 8'hC3);
        send_request(OP_UPPER, 8'h70);
        send_request(OP_INIT, 8'h12);
        set_holds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_CMD, 8'h81);
        send_request(OP_CHAR, 8'h7E);
        send_request(OP_UPPER, 8'hE0);
        send_request(OP_INIT, 8'h00);
        // one gap lands exactly on the maximum, the other just past it
        set_holds(16'd40000, 16'd1, 16'd25536, 16'd25535);
        send_request(OP_INIT, 8'hAA);
        send_request(OP_CHAR, 8'h55);
    endtask

    task automatic test_random_traffic();
        t_op op;
        for (int phase = 0; phase < 6; phase++) begin
            set_holds(random_hold(), random_hold(), random_hold(), random_hold());
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(60, 90)) begin
                if ($urandom_range(0, 99) < 4) begin
                    op = OP_INIT;
                end else begin
                    op = t_op'($urandom_range(0, 2));
                end
                send_request(op, 8'($urandom_range(0, 255)));
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            pin_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            pin_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) begin
                stall_left <= gap_cycles();
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pin_ch.valid && pin_ch.ready) begin
            if (pin_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected pin state, expected none actual %h/%b/%b/%h/%b",
                         $time, pin_ch.data_nibble, pin_ch.reg_select, pin_ch.enable,
                         pin_ch.hold_us, pin_ch.last);
            end else begin
                pin_want = pin_queue.pop_front();
                check_field("data_nibble", 16'(pin_want.data_nibble), 16'(pin_ch.data_nibble));
                check_field("reg_select", 16'(pin_want.reg_select), 16'(pin_ch.reg_select));
                check_field("enable", 16'(pin_want.enable), 16'(pin_ch.enable));
                check_field("hold_us", pin_want.hold_us, pin_ch.hold_us);
                check_field("last", 16'(pin_want.last), 16'(pin_ch.last));
            end
        end
    end

    // no transfer on either channel for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (pin_ch.valid && pin_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_PULSE_HOLD;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = OP_CMD;
        req_ch.value = 8'h00;
        pin_ch.ready = 1'b0;
        errors       = 0;
        steady       = 1'b0;
        stall_left   = 0;
        quiet_cycles = 0;
        holds        = '{RST_PULSE_HOLD, RST_POWERUP_WAIT, RST_WAKE_GAP, RST_CMD_GAP};
        lines_now    = 4'h0;
        rs_now       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up_init();
        test_byte_writes();
        test_hold_extremes();
        test_random_traffic();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pin_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lnws_pkg.sv
rtl/lcd_req_if.sv
rtl/lcd_pin_if.sv
rtl/lnws_front.sv
rtl/lnws_queue.sv
rtl/lnws_back.sv
rtl/lcd_nibble_write_sequencer.sv
test/lcd_nibble_write_sequencer_test.sv
